FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the face normal unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("face normal check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("face normal check failed");

`endif

FILE: hw/rtl/tfn_pkg.sv
// Types and constants of the triangle face normal unit.
package tfn_pkg;

  localparam int CoordW    = 16;
  localparam int EdgeW     = 17;
  localparam int ProdW     = 34;
  localparam int MagW      = 34;
  localparam int HalfW     = 17;
  localparam int SqW       = 68;
  localparam int RadW      = 70;
  localparam int RootW     = 35;
  localparam int RemW      = 38;
  localparam int NumW      = 50;
  localparam int QuotW     = 15;
  localparam int LimitW    = 36;
  localparam int FracShift = 15;
  localparam int SqrtSteps = 35;
  localparam int DivSteps  = 15;

  localparam logic [QuotW-1:0]         OneQ14    = 15'd16384;
  localparam logic signed [CoordW-1:0] OneQ14Out = 16'sd16384;

  // One triangle request.
  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] first_z;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] second_z;
    logic signed [CoordW-1:0] third_x;
    logic signed [CoordW-1:0] third_y;
    logic signed [CoordW-1:0] third_z;
  } tfn_req_t;

  // One normal result.
  typedef struct packed {
    logic signed [CoordW-1:0] unit_x;
    logic signed [CoordW-1:0] unit_y;
    logic signed [CoordW-1:0] unit_z;
    logic                     degenerate;
  } tfn_rsp_t;

  // Cross product components as sign and magnitude.
  typedef struct packed {
    logic [2:0]           neg;
    logic [2:0][MagW-1:0] mag;
  } tfn_mag_t;

endpackage

FILE: hw/rtl/triangle_face_normal.sv
// Triangle face normal unit: cross product, square root and normalising divide.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_req_i (tfn_req_t)
//   out      output     out_valid_o / out_stall_i out_rsp_o (tfn_rsp_t)
//   cfg      input      cfg_we_i                  cfg_wdata_i (degenerate limit)
//
// One request is taken every cycle unless a result waits on a stalled output; 58 register
// stages lie between input and output.
// The depth is set by the 35 one-bit square root stages and the 15 one-bit divide stages.
// Reset clears all valid bits and the limit register; no memory needs clearing.
// The whole pipeline advances only when the output register is empty or being taken.
module triangle_face_normal (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tfn_pkg::tfn_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tfn_pkg::tfn_rsp_t             out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [tfn_pkg::LimitW-1:0]    cfg_wdata_i
);
  import tfn_pkg::*;

  logic                    adv;
  logic [LimitW-1:0]       limit_q;

  logic                    e_vld_q;
  logic signed [EdgeW-1:0] eu_q [3];
  logic signed [EdgeW-1:0] ev_q [3];

  logic                    p_vld_q;
  logic signed [ProdW-1:0] pa_q [3];
  logic signed [ProdW-1:0] pb_q [3];

  logic                    n_vld_q;
  tfn_mag_t                n_nm_q;
  logic signed [ProdW-1:0] n_diff [3];

  logic                    pp_vld_q;
  tfn_mag_t                pp_nm_q;
  logic [2*HalfW-1:0]      pp_hh_q [3];
  logic [2*HalfW-1:0]      pp_hl_q [3];
  logic [2*HalfW-1:0]      pp_ll_q [3];

  logic                    sq_vld_q;
  tfn_mag_t                sq_nm_q;
  logic [SqW-1:0]          sq_q [3];

  logic                    sum_vld_q;
  tfn_mag_t                sum_nm_q;
  logic [SqW-1:0]          sum_q;

  logic                    sr_vld_q  [SqrtSteps];
  logic [RadW-1:0]         sr_rad_q  [SqrtSteps];
  logic [RemW-1:0]         sr_rem_q  [SqrtSteps];
  logic [RootW-1:0]        sr_root_q [SqrtSteps];
  tfn_mag_t                sr_nm_q   [SqrtSteps];

  logic                    dp_vld_q;
  logic                    dp_dgn_q;
  logic [2:0]              dp_neg_q;
  logic [LimitW-1:0]       dp_den_q;
  logic [2:0][NumW-1:0]    dp_rem_q;
  logic [RootW-1:0]        dp_len;

  logic                    dv_vld_q  [DivSteps];
  logic                    dv_dgn_q  [DivSteps];
  logic [2:0]              dv_neg_q  [DivSteps];
  logic [LimitW-1:0]       dv_den_q  [DivSteps];
  logic [2:0][NumW-1:0]    dv_rem_q  [DivSteps];
  logic [2:0][QuotW-1:0]   dv_quot_q [DivSteps];

  logic                    out_valid_q;
  tfn_rsp_t                out_rsp_q;
  tfn_rsp_t                out_rsp_d;

  // The pipeline moves when the output register can take a new result.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Degenerate limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Valid bits of the fixed front stages and the divide preparation stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q   <= 1'b0;
      p_vld_q   <= 1'b0;
      n_vld_q   <= 1'b0;
      pp_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      sum_vld_q <= 1'b0;
      dp_vld_q  <= 1'b0;
    end else if (adv) begin
      e_vld_q   <= in_valid_i;
      p_vld_q   <= e_vld_q;
      n_vld_q   <= p_vld_q;
      pp_vld_q  <= n_vld_q;
      sq_vld_q  <= pp_vld_q;
      sum_vld_q <= sq_vld_q;
      dp_vld_q  <= sr_vld_q[SqrtSteps-1];
    end
  end

  // Edge vectors b - a and c - a.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      eu_q[0] <= {in_req_i.second_x[CoordW-1], in_req_i.second_x}
               - {in_req_i.first_x[CoordW-1], in_req_i.first_x};
      eu_q[1] <= {in_req_i.second_y[CoordW-1], in_req_i.second_y}
               - {in_req_i.first_y[CoordW-1], in_req_i.first_y};
      eu_q[2] <= {in_req_i.second_z[CoordW-1], in_req_i.second_z}
               - {in_req_i.first_z[CoordW-1], in_req_i.first_z};
      ev_q[0] <= {in_req_i.third_x[CoordW-1], in_req_i.third_x}
               - {in_req_i.first_x[CoordW-1], in_req_i.first_x};
      ev_q[1] <= {in_req_i.third_y[CoordW-1], in_req_i.third_y}
               - {in_req_i.first_y[CoordW-1], in_req_i.first_y};
      ev_q[2] <= {in_req_i.third_z[CoordW-1], in_req_i.third_z}
               - {in_req_i.first_z[CoordW-1], in_req_i.first_z};
    end
  end

  // The six products of the cross product.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q[0] <= eu_q[1] * ev_q[2];
      pb_q[0] <= eu_q[2] * ev_q[1];
      pa_q[1] <= eu_q[2] * ev_q[0];
      pb_q[1] <= eu_q[0] * ev_q[2];
      pa_q[2] <= eu_q[0] * ev_q[1];
      pb_q[2] <= eu_q[1] * ev_q[0];
    end
  end

  // Cross product components, split into sign and magnitude.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_diff[k] = pa_q[k] - pb_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        n_nm_q.neg[k] <= n_diff[k][ProdW-1];
        n_nm_q.mag[k] <= n_diff[k][ProdW-1] ? MagW'(-n_diff[k]) : MagW'(n_diff[k]);
      end
    end
  end

  // Partial products of each square, on halves of the magnitude.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_nm_q <= n_nm_q;
      for (int k = 0; k < 3; k++) begin
        pp_hh_q[k] <= n_nm_q.mag[k][MagW-1:HalfW] * n_nm_q.mag[k][MagW-1:HalfW];
        pp_hl_q[k] <= n_nm_q.mag[k][MagW-1:HalfW] * n_nm_q.mag[k][HalfW-1:0];
        pp_ll_q[k] <= n_nm_q.mag[k][HalfW-1:0] * n_nm_q.mag[k][HalfW-1:0];
      end
    end
  end

  // Squares of the components.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_nm_q <= pp_nm_q;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (SqW'(pp_hh_q[k]) << (2 * HalfW))
                 + (SqW'(pp_hl_q[k]) << (HalfW + 1))
                 + SqW'(pp_ll_q[k]);
      end
    end
  end

  // Squared length.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_nm_q <= sq_nm_q;
      sum_q    <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // Square root, one result bit per stage, most significant first.
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic             vld_in;
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    tfn_mag_t         nm_in;
    logic [RemW-1:0]  rem_try;
    logic [RemW-1:0]  trial;
    logic             take;

    if (i == 0) begin : g_first
      assign vld_in  = sum_vld_q;
      assign rad_in  = {2'b00, sum_q};
      assign rem_in  = '0;
      assign root_in = '0;
      assign nm_in   = sum_nm_q;
    end else begin : g_next
      assign vld_in  = sr_vld_q[i-1];
      assign rad_in  = sr_rad_q[i-1];
      assign rem_in  = sr_rem_q[i-1];
      assign root_in = sr_root_q[i-1];
      assign nm_in   = sr_nm_q[i-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rem_try = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
    assign trial   = RemW'({root_in, 2'b01});
    assign take    = rem_try >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_vld_q[i] <= 1'b0;
      end else if (adv) begin
        sr_vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_rad_q[i]  <= rad_in << 2;
        sr_rem_q[i]  <= take ? rem_try - trial : rem_try;
        sr_root_q[i] <= {root_in[RootW-2:0], take};
        sr_nm_q[i]   <= nm_in;
      end
    end
  end

  // Divide set-up: dividends 2*16384*m + L, divisor 2*L, degenerate test.
  assign dp_len = sr_root_q[SqrtSteps-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_dgn_q <= LimitW'(dp_len) <= limit_q;
      dp_neg_q <= sr_nm_q[SqrtSteps-1].neg;
      dp_den_q <= {dp_len, 1'b0};
      for (int k = 0; k < 3; k++) begin
        dp_rem_q[k] <= NumW'({sr_nm_q[SqrtSteps-1].mag[k], {FracShift{1'b0}}})
                     + NumW'(dp_len);
      end
    end
  end

  // Restoring divide, one quotient bit per stage for all three lanes.
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int Shift = DivSteps - 1 - j;

    logic                  vld_in;
    logic                  dgn_in;
    logic [2:0]            neg_in;
    logic [LimitW-1:0]     den_in;
    logic [2:0][NumW-1:0]  rem_in;
    logic [2:0][QuotW-1:0] quot_in;
    logic [NumW-1:0]       den_sh;
    logic [2:0]            take;

    if (j == 0) begin : g_first
      assign vld_in  = dp_vld_q;
      assign dgn_in  = dp_dgn_q;
      assign neg_in  = dp_neg_q;
      assign den_in  = dp_den_q;
      assign rem_in  = dp_rem_q;
      assign quot_in = '0;
    end else begin : g_next
      assign vld_in  = dv_vld_q[j-1];
      assign dgn_in  = dv_dgn_q[j-1];
      assign neg_in  = dv_neg_q[j-1];
      assign den_in  = dv_den_q[j-1];
      assign rem_in  = dv_rem_q[j-1];
      assign quot_in = dv_quot_q[j-1];
    end

    assign den_sh = NumW'(den_in) << Shift;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        take[k] = rem_in[k] >= den_sh;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_dgn_q[j] <= dgn_in;
        dv_neg_q[j] <= neg_in;
        dv_den_q[j] <= den_in;
        for (int k = 0; k < 3; k++) begin
          dv_rem_q[j][k]  <= take[k] ? rem_in[k] - den_sh : rem_in[k];
          dv_quot_q[j][k] <= {quot_in[k][QuotW-2:0], take[k]};
        end
      end
    end
  end

  // Saturate, apply the sign and choose the default normal when degenerate.
  always_comb begin
    logic [QuotW-1:0]         q_sat [3];
    logic signed [CoordW-1:0] comp  [3];
    for (int k = 0; k < 3; k++) begin
      q_sat[k] = (dv_quot_q[DivSteps-1][k] > OneQ14) ? OneQ14 : dv_quot_q[DivSteps-1][k];
      comp[k]  = dv_neg_q[DivSteps-1][k] ? -CoordW'(q_sat[k]) : CoordW'(q_sat[k]);
    end
    if (dv_dgn_q[DivSteps-1]) begin
      out_rsp_d.unit_x     = '0;
      out_rsp_d.unit_y     = '0;
      out_rsp_d.unit_z     = OneQ14Out;
      out_rsp_d.degenerate = 1'b1;
    end else begin
      out_rsp_d.unit_x     = comp[0];
      out_rsp_d.unit_y     = comp[1];
      out_rsp_d.unit_z     = comp[2];
      out_rsp_d.degenerate = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_vld_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

FILE: hw/rtl/tfn_checker.sv
// Port-level checker of the triangle face normal unit and its bind.
`include "assert_macros.svh"

module tfn_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input tfn_pkg::tfn_req_t          in_req_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input tfn_pkg::tfn_rsp_t          out_rsp_o,
  input logic                       cfg_we_i,
  input logic [tfn_pkg::LimitW-1:0] cfg_wdata_i
);
  import tfn_pkg::*;

  // A stalled result stays and holds its value.
  `TFN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))

  // Requests are held back only while a result waits on a stalled output.
  `TFN_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A degenerate triangle gives the default normal.
  `TFN_ASSERT_IMP(a_dgn_default, clk_i, rst_ni, out_valid_o && out_rsp_o.degenerate, (out_rsp_o.unit_x == 16'sd0) && (out_rsp_o.unit_y == 16'sd0) && (out_rsp_o.unit_z == OneQ14Out))

  // Normal components stay within plus or minus one in Q1.14.
  `TFN_ASSERT_IMP(a_unit_range, clk_i, rst_ni, out_valid_o && !out_rsp_o.degenerate, (out_rsp_o.unit_x >= -OneQ14Out) && (out_rsp_o.unit_x <= OneQ14Out) && (out_rsp_o.unit_y >= -OneQ14Out) && (out_rsp_o.unit_y <= OneQ14Out) && (out_rsp_o.unit_z >= -OneQ14Out) && (out_rsp_o.unit_z <= OneQ14Out))

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);
